FILE: rtl/core/nfca_pkg.sv
// Package for the nearest free color allocator: pixel and result beat types,
// the octant fallback order and small shared constants. No dependencies.
`default_nettype none

package nfca_pkg;

  localparam int CHAN_W = 4;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              exhausted;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

  localparam logic [2:0] FALLBACK_XOR [8] = '{3'd0, 3'd1, 3'd4, 3'd5,
                                               3'd2, 3'd3, 3'd6, 3'd7};
  localparam logic [2:0] PROBE_LAST = 3'd7;

endpackage

`default_nettype wire

FILE: rtl/core/nfca_count_mem.sv
// Count memory of the allocator: one used count per octree node, one write
// and one registered read per cycle. Depends on nfca_pkg for the command type.
`default_nettype none

module nfca_count_mem import nfca_pkg::*; #(
  parameter int DEPTH  = 4681,
  parameter int ADDR_W = 13,
  parameter int CNT_W  = 13
) (
  input  wire logic              clk,
  input  wire mem_cmd_t          cmd,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [CNT_W-1:0]  wr_data,
  output      logic [CNT_W-1:0]  rd_data
);

  logic [CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nfca_ctrl.sv
// Sequencer of the allocator: clearing pass, octree descent with octant
// fallback, and the read-modify-write of the path counts. Depends on nfca_pkg.
`default_nettype none

module nfca_ctrl import nfca_pkg::*; #(
  parameter int BITS   = 4,
  parameter int DEPTH  = 4681,
  parameter int ADDR_W = 13,
  parameter int CNT_W  = 13
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire pix_t              in_pix,
  output      mem_cmd_t          cmd,
  output      logic [ADDR_W-1:0] rd_addr,
  output      logic [ADDR_W-1:0] wr_addr,
  output      logic [CNT_W-1:0]  wr_data,
  input  wire logic [CNT_W-1:0]  rd_data,
  output      logic              res_valid,
  output      res_t              res
);

  localparam int LVL_W = $clog2(BITS + 1);
  localparam int ST_W  = 3;

  localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [ST_W-1:0] ST_ROOT  = 3'd2;
  localparam logic [ST_W-1:0] ST_PROBE = 3'd3;
  localparam logic [ST_W-1:0] ST_UPD   = 3'd4;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [BITS-1:0]   r_sh_r, r_sh_nxt, g_sh_r, g_sh_nxt, b_sh_r, b_sh_nxt;
  logic [BITS-1:0]   r_col_r, r_col_nxt, g_col_r, g_col_nxt, b_col_r, b_col_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [LVL_W-1:0]  upd_r, upd_nxt;
  logic [2:0]        t_r, t_nxt;
  logic [ADDR_W-1:0] probe_addr_r, probe_addr_nxt;
  logic [ADDR_W-1:0] path_r [BITS+1];
  logic [ADDR_W-1:0] path_nxt [BITS+1];

  logic [2:0]        want, next_want, cand;
  logic [BITS-1:0]   r_shl, g_shl, b_shl;
  logic [ADDR_W-1:0] node;

  function automatic logic [CNT_W-1:0] full_at(input logic [LVL_W-1:0] depth);
    full_at = CNT_W'(1) << (3 * (BITS - int'(depth)));
  endfunction

  function automatic logic [ADDR_W-1:0] child_of(input logic [ADDR_W-1:0] parent,
                                                 input logic [2:0] oct);
    child_of = ADDR_W'({parent, oct}) + ADDR_W'(1);
  endfunction

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    r_shl     = r_sh_r << 1;
    g_shl     = g_sh_r << 1;
    b_shl     = b_sh_r << 1;
    want      = {r_sh_r[BITS-1], g_sh_r[BITS-1], b_sh_r[BITS-1]};
    next_want = {r_shl[BITS-1], g_shl[BITS-1], b_shl[BITS-1]};
    cand      = want ^ FALLBACK_XOR[t_r];
    node      = path_r[lvl_r];
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    r_sh_nxt       = r_sh_r;
    g_sh_nxt       = g_sh_r;
    b_sh_nxt       = b_sh_r;
    r_col_nxt      = r_col_r;
    g_col_nxt      = g_col_r;
    b_col_nxt      = b_col_r;
    lvl_nxt        = lvl_r;
    upd_nxt        = upd_r;
    t_nxt          = t_r;
    probe_addr_nxt = probe_addr_r;
    path_nxt       = path_r;
    cmd            = '0;
    rd_addr        = '0;
    wr_addr        = '0;
    wr_data        = '0;
    res_valid      = 1'b0;
    res            = '0;

    case (state_r)
      ST_CLEAR: begin
        cmd.wr_en = 1'b1;
        wr_addr   = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          r_sh_nxt    = BITS'(in_pix.red_in);
          g_sh_nxt    = BITS'(in_pix.green_in);
          b_sh_nxt    = BITS'(in_pix.blue_in);
          r_col_nxt   = '0;
          g_col_nxt   = '0;
          b_col_nxt   = '0;
          lvl_nxt     = '0;
          path_nxt[0] = '0;
          cmd.rd_en   = 1'b1;
          rd_addr     = '0;
          state_nxt   = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rd_data >= full_at('0)) begin
          res_valid     = 1'b1;
          res.exhausted = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          t_nxt          = '0;
          probe_addr_nxt = child_of('0, want ^ FALLBACK_XOR[0]);
          cmd.rd_en      = 1'b1;
          rd_addr        = probe_addr_nxt;
          state_nxt      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (rd_data < full_at(lvl_r + LVL_W'(1))) begin
          path_nxt[lvl_r + LVL_W'(1)] = probe_addr_r;
          r_col_nxt = (r_col_r << 1) | BITS'(cand[2]);
          g_col_nxt = (g_col_r << 1) | BITS'(cand[1]);
          b_col_nxt = (b_col_r << 1) | BITS'(cand[0]);
          r_sh_nxt  = r_shl;
          g_sh_nxt  = g_shl;
          b_sh_nxt  = b_shl;
          cmd.rd_en = 1'b1;
          if (lvl_r == LVL_W'(BITS - 1)) begin
            rd_addr   = path_r[0];
            upd_nxt   = '0;
            state_nxt = ST_UPD;
          end else begin
            lvl_nxt        = lvl_r + LVL_W'(1);
            t_nxt          = '0;
            probe_addr_nxt = child_of(probe_addr_r, next_want ^ FALLBACK_XOR[0]);
            rd_addr        = probe_addr_nxt;
          end
        end else if (t_r == PROBE_LAST) begin
          res_valid     = 1'b1;
          res.exhausted = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          t_nxt          = t_r + 3'd1;
          probe_addr_nxt = child_of(node, want ^ FALLBACK_XOR[t_nxt]);
          cmd.rd_en      = 1'b1;
          rd_addr        = probe_addr_nxt;
        end
      end
      ST_UPD: begin
        cmd.wr_en = 1'b1;
        wr_addr   = path_r[upd_r];
        wr_data   = rd_data + CNT_W'(1);
        if (upd_r == LVL_W'(BITS)) begin
          res_valid     = 1'b1;
          res.red_out   = CHAN_W'(r_col_r);
          res.green_out = CHAN_W'(g_col_r);
          res.blue_out  = CHAN_W'(b_col_r);
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = path_r[upd_r + LVL_W'(1)];
          upd_nxt   = upd_r + LVL_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_sh_r       <= r_sh_nxt;
    g_sh_r       <= g_sh_nxt;
    b_sh_r       <= b_sh_nxt;
    r_col_r      <= r_col_nxt;
    g_col_r      <= g_col_nxt;
    b_col_r      <= b_col_nxt;
    lvl_r        <= lvl_nxt;
    upd_r        <= upd_nxt;
    t_r          <= t_nxt;
    probe_addr_r <= probe_addr_nxt;
    path_r       <= path_nxt;
  end

  a_res_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> state_r == ST_IDLE)
    else $error("result beat not followed by idle");

  a_accept_reads_root: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_ROOT))
    else $error("accepted pixel did not start with the root read");

  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same count entry");

  a_upd_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (wr_data != '0))
    else $error("path count update wrapped");

endmodule

`default_nettype wire

FILE: rtl/core/nearest_free_color_allocator.sv
// Top level of the nearest free color allocator: sequencer, count memory and
// the result register. Depends on nfca_pkg, nfca_ctrl and nfca_count_mem.
//
// Each pixel beat is taken when start is high and busy is low. Its result
// beat appears on out_res for one cycle with out_valid, and the receiver
// cannot stall it. Counts live in one memory with one read per cycle, so
// a pixel runs a root read, BITS to 8*BITS octant probes, then an increment
// of each of the BITS+1 path counts, with busy high throughout. An exhausted
// pool is found at the root read. The result beat is on the ports in the first
// cycle that busy is low again. After reset a clearing pass over all
// (8^(BITS+1)-1)/7 count entries (4681 at BITS=4) runs with busy high.
`default_nettype none

module nearest_free_color_allocator import nfca_pkg::*; #(
  parameter int BITS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output      logic busy,
  input  wire pix_t in_pix,
  output      logic out_valid,
  output      res_t out_res
);

  localparam int DEPTH  = ((1 << (3 * (BITS + 1))) - 1) / 7;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 3 * BITS + 1;

  mem_cmd_t          cmd;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic [CNT_W-1:0]  rd_data;
  logic              res_valid;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;

  nfca_ctrl #(
    .BITS   (BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pix    (in_pix),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  nfca_count_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_mem (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire
